// ----- rtl/core/sapq_pkg.sv -----
`default_nettype none

package sapq_pkg;

    localparam int unsigned DEPTH_DEF = 16;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned OCC_W     = 5;

    typedef enum logic [1:0] {
        OP_INSERT    = 2'd0,
        OP_DELETE    = 2'd1,
        OP_PEEK_MAX  = 2'd2,
        OP_PEEK_MIN  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef struct packed {
        op_t                       operation;
        logic signed [DATA_W-1:0]  value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  result_value;
        status_t                   status;
        logic [OCC_W-1:0]          occupancy;
    } rsp_t;

    // broadcast to every cell
    typedef struct packed {
        logic                      ins;
        logic                      del;
        logic signed [DATA_W-1:0]  value;
    } cell_cmd_t;

    // what a cell shows its neighbours
    typedef struct packed {
        logic                      take;
        logic                      valid;
        logic signed [DATA_W-1:0]  entry;
    } cell_link_t;

endpackage

`default_nettype wire

// ----- rtl/core/sapq_cell.sv -----
`default_nettype none

module sapq_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sapq_pkg::cell_cmd_t  cmd,
    input  wire sapq_pkg::cell_link_t left,
    input  wire sapq_pkg::cell_link_t right,
    output sapq_pkg::cell_link_t      link
);

    logic                                  valid_reg;
    logic                                  valid_next;
    logic signed [sapq_pkg::DATA_W-1:0]    entry_reg;
    logic signed [sapq_pkg::DATA_W-1:0]    entry_next;
    logic                                  take;

    // slot is free or the new word outranks what it holds
    assign take = !valid_reg || (cmd.value > entry_reg);

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (cmd.ins)
        begin
            valid_next = valid_reg | left.valid;
            if (left.take)
            begin
                entry_next = left.entry;
            end
            else if (take)
            begin
                entry_next = cmd.value;
            end
        end
        else if (cmd.del)
        begin
            valid_next = right.valid;
            entry_next = right.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign link.take  = take;
    assign link.valid = valid_reg;
    assign link.entry = entry_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sorted_array_priority_queue_unit.sv -----
`default_nettype none

// Bounded priority queue of signed 32-bit words held in descending order in a
// row of DEPTH cells. Every cell compares the incoming word against its own
// entry at once, so an insert, delete or peek is taken each clock cycle and
// its response appears in the output register on the next cycle; one word
// per cycle is sustained while the response side keeps up. Equal words leave
// in arrival order. The smallest entry is tracked in a separate tail register
// so peek-smallest needs no search. Storage starts empty after reset with no
// clearing pass.

module sorted_array_priority_queue_unit #(
    parameter int unsigned DEPTH = sapq_pkg::DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire sapq_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output sapq_pkg::rsp_t     rsp
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    sapq_pkg::cell_cmd_t                   cmd;
    sapq_pkg::cell_link_t                  links [DEPTH];
    sapq_pkg::cell_link_t                  edge_left;
    sapq_pkg::cell_link_t                  edge_right;

    logic [CNT_W-1:0]                      count_reg;
    logic [CNT_W-1:0]                      count_next;
    logic signed [sapq_pkg::DATA_W-1:0]    tail_reg;
    logic signed [sapq_pkg::DATA_W-1:0]    tail_next;
    logic                                  rsp_valid_reg;
    logic                                  rsp_valid_next;
    sapq_pkg::rsp_t                        rsp_reg;
    sapq_pkg::rsp_t                        rsp_next;

    logic accept;
    logic empty;
    logic full;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign empty     = !links[0].valid;
    assign full      = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        cmd.ins        = 1'b0;
        cmd.del        = 1'b0;
        cmd.value      = req.value;
        count_next     = count_reg;
        tail_next      = tail_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (accept)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.result_value = '0;
            rsp_next.status       = sapq_pkg::ST_OK;
            case (req.operation)
                sapq_pkg::OP_INSERT:
                begin
                    if (full)
                    begin
                        rsp_next.status = sapq_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        cmd.ins    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        // new word goes last unless it beats the tail
                        if (empty || !(req.value > tail_reg))
                        begin
                            tail_next = req.value;
                        end
                    end
                end
                sapq_pkg::OP_DELETE:
                begin
                    if (empty)
                    begin
                        rsp_next.status = sapq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cmd.del               = 1'b1;
                        count_next            = count_reg - CNT_W'(1);
                        rsp_next.result_value = links[0].entry;
                    end
                end
                sapq_pkg::OP_PEEK_MAX:
                begin
                    if (empty)
                    begin
                        rsp_next.status = sapq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rsp_next.result_value = links[0].entry;
                    end
                end
                sapq_pkg::OP_PEEK_MIN:
                begin
                    if (empty)
                    begin
                        rsp_next.status = sapq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rsp_next.result_value = tail_reg;
                    end
                end
                default:
                begin
                    rsp_next.status = sapq_pkg::ST_EMPTY;
                end
            endcase
            rsp_next.occupancy = sapq_pkg::OCC_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_reg <= tail_next;
        rsp_reg  <= rsp_next;
    end

    // head cell sees a full, non-displacing neighbour; tail cell an empty one
    assign edge_left.take   = 1'b0;
    assign edge_left.valid  = 1'b1;
    assign edge_left.entry  = '0;
    assign edge_right.take  = 1'b1;
    assign edge_right.valid = 1'b0;
    assign edge_right.entry = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        sapq_pkg::cell_link_t left_link;
        sapq_pkg::cell_link_t right_link;

        if (i == 0)
        begin : g_first
            assign left_link = edge_left;
        end
        else
        begin : g_mid_l
            assign left_link = links[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_link = edge_right;
        end
        else
        begin : g_mid_r
            assign right_link = links[i+1];
        end

        sapq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .left  (left_link),
            .right (right_link),
            .link  (links[i])
        );
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sapq_checker.sv -----
`default_nettype none

module sapq_checker #(
    parameter int unsigned DEPTH = sapq_pkg::DEPTH_DEF
) (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_ready,
    input wire sapq_pkg::req_t req,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire sapq_pkg::rsp_t rsp
);

    localparam logic [sapq_pkg::OCC_W-1:0] FULL_OCC = sapq_pkg::OCC_W'(DEPTH);

    // an idle output side never holds back a request
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request stalled with no word pending");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> rsp_valid)
        else $error("accepted word produced no response");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == sapq_pkg::ST_EMPTY)
            |-> (rsp.occupancy == '0 && rsp.result_value == '0))
        else $error("empty status with entries held");

    a_overflow_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == sapq_pkg::ST_OVERFLOW)
            |-> (rsp.occupancy == FULL_OCC))
        else $error("overflow reported below capacity");

endmodule

bind sorted_array_priority_queue_unit sapq_checker #(.DEPTH(DEPTH)) u_sapq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire
